>>> sv/sdcrc_pkg.sv
package sdcrc_pkg;

  // operation codes
  localparam logic [1:0] OP_BUILD = 2'd0;
  localparam logic [1:0] OP_R1    = 2'd1;
  localparam logic [1:0] OP_R3    = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_CRC_ERR = 2'd1;
  localparam logic [1:0] ST_IDX_ERR = 2'd2;

  localparam logic [7:0] FRAME_BITS_M1 = 8'd47;
  localparam logic [5:0] IDX_EXEMPT    = 6'd41;
  localparam logic [7:0] CRC7_POLY     = 8'h12;
  localparam int         MSG_BITS      = 40;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [5:0]  command_index;
    logic [31:0] argument;
    logic [7:0]  resp_len_bits;
    logic [31:0] resp_high_word;
    logic [15:0] resp_low_half;
  } in_t;

  typedef struct packed {
    logic [31:0] frame_word_a;
    logic [31:0] frame_word_b;
    logic [1:0]  status;
    logic [31:0] card_status;
  } out_t;

  // one request in flight: its fields, the bytes still to fold in, partial CRC
  typedef struct packed {
    in_t                 item;
    logic [MSG_BITS-1:0] msg;
    logic [7:0]          crc;
  } stage_t;

  // CRC7 kept left-aligned in 8 bits, one byte MSB first
  function automatic logic [7:0] crc7_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC7_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> sv/sdcrc_crc_stage.sv
module sdcrc_crc_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_stall,
  input  sdcrc_pkg::stage_t up_data,
  output logic            dn_valid,
  input  logic            dn_stall,
  output sdcrc_pkg::stage_t dn_data
);

  logic              valid_r;
  sdcrc_pkg::stage_t data_r;
  sdcrc_pkg::stage_t data_nxt;
  logic              advance;

  assign advance  = !valid_r || !dn_stall;
  assign up_stall = !advance;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  // fold the leading byte into the CRC, then shift it out
  always_comb begin
    data_nxt      = up_data;
    data_nxt.crc  = sdcrc_pkg::crc7_byte(up_data.crc,
                                         up_data.msg[sdcrc_pkg::MSG_BITS-1 -: 8]);
    data_nxt.msg  = {up_data.msg[sdcrc_pkg::MSG_BITS-9:0], 8'h00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

>>> sv/sdcrc_finish.sv
module sdcrc_finish (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_stall,
  input  sdcrc_pkg::stage_t up_data,
  output logic              out_valid,
  input  logic              out_stall,
  output sdcrc_pkg::out_t   out_data
);

  logic            valid_r;
  sdcrc_pkg::out_t res_r;
  sdcrc_pkg::out_t res_nxt;
  logic            advance;
  logic [7:0]      crc;
  logic [31:0]     payload;
  sdcrc_pkg::in_t  it;

  assign advance   = !valid_r || !out_stall;
  assign up_stall  = !advance;
  assign out_valid = valid_r;
  assign out_data  = res_r;

  always_comb begin
    it      = up_data.item;
    crc     = sdcrc_pkg::crc7_byte(up_data.crc, up_data.msg[sdcrc_pkg::MSG_BITS-1 -: 8]);
    payload = {it.resp_high_word[23:0], it.resp_low_half[15:8]};
    res_nxt = '0;
    unique case (it.cmd)
      sdcrc_pkg::OP_BUILD: begin
        res_nxt.frame_word_a = {sdcrc_pkg::FRAME_BITS_M1, 2'b01, it.command_index,
                                it.argument[31:16]};
        res_nxt.frame_word_b = {it.argument[15:0], crc[7:1], 1'b1,
                                (it.resp_len_bits == 8'd0) ? 8'd0 : it.resp_len_bits - 8'd1};
      end
      sdcrc_pkg::OP_R1: begin
        // CRC wins over index; the end bit is masked off the received CRC
        if (crc != {it.resp_low_half[7:1], 1'b0}) begin
          res_nxt.status = sdcrc_pkg::ST_CRC_ERR;
        end else if (it.resp_high_word[31:24] != {2'b00, it.command_index} &&
                     it.command_index != sdcrc_pkg::IDX_EXEMPT) begin
          res_nxt.status = sdcrc_pkg::ST_IDX_ERR;
        end else begin
          res_nxt.card_status = payload;
        end
      end
      sdcrc_pkg::OP_R3: begin
        res_nxt.card_status = payload;
      end
      default: begin
        res_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && up_valid) begin
      res_r <= res_nxt;
    end
  end

endmodule

>>> sv/sd_command_frame_crc7_core.sv
// Throughput: one request per cycle while the output is not stalled; the rate is set
//   by the five-stage CRC7 pipeline, one header byte folded into the CRC in each stage.
// Reset: synchronous, active low; it clears the stage valid bits only, data registers
//   keep whatever they hold until the next request loads them.
module sd_command_frame_crc7_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  sdcrc_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output sdcrc_pkg::out_t out_data
);

  localparam int CRC_STAGES = 4;

  // Stage links: link k feeds CRC stage k, link CRC_STAGES feeds the finish stage.
  logic              link_valid [CRC_STAGES+1];
  logic              link_stall [CRC_STAGES+1];
  sdcrc_pkg::stage_t link_data  [CRC_STAGES+1];

  // Pick the five bytes that the CRC covers. A command frame covers the
  // start/direction/index byte and the argument; a response check covers the
  // echoed index byte, the status bytes and the last status byte. For an R3
  // extract or an unknown code the CRC is computed but never used.
  always_comb begin
    link_data[0].item = in_data;
    link_data[0].crc  = 8'h00;
    if (in_data.cmd == sdcrc_pkg::OP_BUILD) begin
      link_data[0].msg = {2'b01, in_data.command_index, in_data.argument};
    end else begin
      link_data[0].msg = {in_data.resp_high_word, in_data.resp_low_half[15:8]};
    end
  end

  assign link_valid[0] = in_valid;
  assign in_stall      = link_stall[0];

  // Four header bytes, one per stage; each stage holds its request while
  // the next one is stalled.
  for (genvar k = 0; k < CRC_STAGES; k++) begin : g_crc
    sdcrc_crc_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (link_valid[k]),
      .up_stall (link_stall[k]),
      .up_data  (link_data[k]),
      .dn_valid (link_valid[k+1]),
      .dn_stall (link_stall[k+1]),
      .dn_data  (link_data[k+1])
    );
  end

  // Fold the last byte, check or frame, and hold the result until taken.
  sdcrc_finish u_finish (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (link_valid[CRC_STAGES]),
    .up_stall  (link_stall[CRC_STAGES]),
    .up_data   (link_data[CRC_STAGES]),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
